// ===== hw/rtl/template_atom_matcher_core_defines.svh =====
// ----------------------------------------------------------------------------
// template atom matcher assertion macros
// shared assertion wrappers for the matcher checker
// ----------------------------------------------------------------------------
`ifndef TEMPLATE_ATOM_MATCHER_CORE_DEFINES_SVH
`define TEMPLATE_ATOM_MATCHER_CORE_DEFINES_SVH

// assertion that is ignored while reset is high
`define TAM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that is also checked across reset
`define TAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tam_pkg.sv =====
// ----------------------------------------------------------------------------
// tam_pkg
// types, codes and name-compare helpers of the template atom matcher
// ----------------------------------------------------------------------------
`default_nettype none

package tam_pkg;

   localparam int DEF_MAX_ATOM_NAMES    = 8;
   localparam int DEF_MAX_RESIDUE_NAMES = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request op codes
   localparam logic [1:0] OP_MATCH    = 2'd0;
   localparam logic [1:0] OP_LOAD_ATM = 2'd1;
   localparam logic [1:0] OP_LOAD_RES = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_MATCH_MODE = 2'd0;
   localparam logic [1:0] CSR_ATOM_CNT   = 2'd1;
   localparam logic [1:0] CSR_RES_CNT    = 2'd2;

   // match mode codes
   localparam logic signed [7:0] MODE_NAME_RES_ALT = -8'sd1;
   localparam logic signed [7:0] MODE_NAME_RES     = 8'sd0;
   localparam logic signed [7:0] MODE_SIDE_RES     = 8'sd1;
   localparam logic signed [7:0] MODE_NOCH_RES     = 8'sd2;
   localparam logic signed [7:0] MODE_TYPE_RES     = 8'sd3;
   localparam logic signed [7:0] MODE_NOC_MC_RES   = 8'sd4;
   localparam logic signed [7:0] MODE_MC_RES       = 8'sd5;
   localparam logic signed [7:0] MODE_NOMC_RES     = 8'sd6;
   localparam logic signed [7:0] MODE_NOH_RES      = 8'sd7;
   localparam logic signed [7:0] MODE_POS_RES      = 8'sd8;
   localparam logic signed [7:0] MODE_NAME         = 8'sd100;
   localparam logic signed [7:0] MODE_SIDE         = 8'sd101;
   localparam logic signed [7:0] MODE_NOC          = 8'sd102;
   localparam logic signed [7:0] MODE_TYPE         = 8'sd103;
   localparam logic signed [7:0] MODE_NOC_MC       = 8'sd104;
   localparam logic signed [7:0] MODE_MC           = 8'sd105;
   localparam logic signed [7:0] MODE_NOMC         = 8'sd106;
   localparam logic signed [7:0] MODE_ANY          = 8'sd107;

   localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0]  CHAR_C          = 8'h43;
   localparam logic [7:0]  CHAR_H          = 8'h48;
   localparam logic [31:0] NAME_CA         = 32'h5F43_415F;
   localparam logic [31:0] NAME_N          = 32'h5F4E_5F5F;
   localparam logic [31:0] NAME_O          = 32'h5F4F_5F5F;

   typedef enum logic [1:0] {
      KIND_MATCH    = 2'd0,
      KIND_LOAD_ATM = 2'd1,
      KIND_LOAD_RES = 2'd2,
      KIND_DROP     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  entry_index;
      logic [31:0] atom_name;
      logic [23:0] residue_name;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic [7:0] match_mode;
      logic [3:0] atom_name_count;
      logic [5:0] residue_name_count;
   } cfg_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   function automatic logic same_atom_nocase(input logic [31:0] a, input logic [31:0] b);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (fold_char(a[8*i +: 8]) != fold_char(b[8*i +: 8])) begin
            eq = 1'b0;
         end
      end
      return eq;
   endfunction

   function automatic logic same_res_nocase(input logic [23:0] a, input logic [23:0] b);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (fold_char(a[8*i +: 8]) != fold_char(b[8*i +: 8])) begin
            eq = 1'b0;
         end
      end
      return eq;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tam_front.sv =====
// ----------------------------------------------------------------------------
// tam_front
// request intake: classifies requests, queues undropped ones for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tam_front import tam_pkg::*; #(
   parameter int MAX_ATOM_NAMES    = DEF_MAX_ATOM_NAMES,
   parameter int MAX_RESIDUE_NAMES = DEF_MAX_RESIDUE_NAMES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // entry_index, atom_name, residue_name
   input  wire logic [1:0]  req_tuser,  // op
   output q_head_type       head,
   input  wire logic        pop
);

   item_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   item_type             new_item;
   logic                 push;

   always_comb begin
      new_item.entry_index  = req_tdata[4:0];
      new_item.atom_name    = req_tdata[36:5];
      new_item.residue_name = req_tdata[60:37];
      unique case (req_tuser)
         OP_MATCH:    new_item.kind = KIND_MATCH;
         OP_LOAD_ATM: new_item.kind = (32'(req_tdata[4:0]) < MAX_ATOM_NAMES) ?
                                      KIND_LOAD_ATM : KIND_DROP;
         OP_LOAD_RES: new_item.kind = (32'(req_tdata[4:0]) < MAX_RESIDUE_NAMES) ?
                                      KIND_LOAD_RES : KIND_DROP;
         default:     new_item.kind = KIND_DROP;
      endcase
   end

   assign req_tready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   // requests with no effect are taken and dropped here
   assign push       = req_tvalid && req_tready && (new_item.kind != KIND_DROP);

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tam_back.sv =====
// ----------------------------------------------------------------------------
// tam_back
// template tables, parallel compare stage and mode decode into the response
// ----------------------------------------------------------------------------
`default_nettype none

module tam_back import tam_pkg::*; #(
   parameter int MAX_ATOM_NAMES    = DEF_MAX_ATOM_NAMES,
   parameter int MAX_RESIDUE_NAMES = DEF_MAX_RESIDUE_NAMES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_head_type head,
   output logic            pop,
   input  wire cfg_type    cfg,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata   // is_match, bad_mode
);

   logic [31:0] atm_tab_ff [MAX_ATOM_NAMES];
   logic [23:0] res_tab_ff [MAX_RESIDUE_NAMES];

   // compare stage
   logic                         s1_valid_ff, s1_valid_in;
   logic [MAX_ATOM_NAMES-1:0]    name_vec_ff, name_vec_in;
   logic [MAX_ATOM_NAMES-1:0]    type_vec_ff, type_vec_in;
   logic [MAX_ATOM_NAMES-1:0]    pos_vec_ff, pos_vec_in;
   logic [MAX_RESIDUE_NAMES-1:0] res_vec_ff, res_vec_in;
   logic                         carbon_ff, carbon_in;
   logic                         hydro_ff, hydro_in;
   logic                         main_ff, main_in;

   // response register
   logic out_valid_ff, out_valid_in;
   logic is_match_ff, is_match_in;
   logic bad_mode_ff, bad_mode_in;

   logic s1_adv;
   logic s1_load;
   int   atom_lim;
   int   res_lim;
   logic [31:0] nm;
   logic [23:0] rn;
   logic signed [7:0] mode;
   logic name_hit, type_hit, pos_hit, res_hit;

   assign s1_adv  = !out_valid_ff || rsp_tready;
   assign s1_load = !s1_valid_ff || s1_adv;
   assign pop     = head.valid && s1_load;
   assign nm      = head.item.atom_name;
   assign rn      = head.item.residue_name;

   always_comb begin
      atom_lim = (32'(cfg.atom_name_count) > MAX_ATOM_NAMES) ?
                 MAX_ATOM_NAMES : 32'(cfg.atom_name_count);
      res_lim  = (32'(cfg.residue_name_count) > MAX_RESIDUE_NAMES) ?
                 MAX_RESIDUE_NAMES : 32'(cfg.residue_name_count);
   end

   always_comb begin
      for (int k = 0; k < MAX_ATOM_NAMES; k++) begin
         name_vec_in[k] = (k < atom_lim) && same_atom_nocase(nm, atm_tab_ff[k]);
         if (nm[31:24] == CHAR_UNDERSCORE) begin
            type_vec_in[k] = (nm[23:16] == atm_tab_ff[k][23:16]);
            pos_vec_in[k]  = (nm[15:8] == atm_tab_ff[k][15:8]);
         end else begin
            type_vec_in[k] = (nm[31:16] == atm_tab_ff[k][31:16]);
            pos_vec_in[k]  = (nm[23:8] == atm_tab_ff[k][23:8]);
         end
         type_vec_in[k] = type_vec_in[k] && (k < atom_lim);
         pos_vec_in[k]  = pos_vec_in[k] && (k < atom_lim);
      end
      for (int k = 0; k < MAX_RESIDUE_NAMES; k++) begin
         res_vec_in[k] = (k < res_lim) && same_res_nocase(rn, res_tab_ff[k]);
      end
      carbon_in = (nm[31:24] == CHAR_UNDERSCORE) && (nm[23:16] == CHAR_C);
      hydro_in  = (nm[31:24] == CHAR_UNDERSCORE) && (nm[23:16] == CHAR_H);
      main_in   = same_atom_nocase(nm, NAME_CA) || same_atom_nocase(nm, NAME_N) ||
                  same_atom_nocase(nm, NAME_O);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = pop && (head.item.kind == KIND_MATCH);
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
      end
   end

   assign mode     = $signed(cfg.match_mode);
   assign name_hit = |name_vec_ff;
   assign type_hit = |type_vec_ff;
   assign pos_hit  = |pos_vec_ff;
   assign res_hit  = |res_vec_ff;

   always_comb begin
      bad_mode_in = 1'b0;
      unique case (mode) inside
         MODE_NAME_RES_ALT, MODE_NAME_RES: is_match_in = name_hit && res_hit;
         MODE_SIDE_RES:   is_match_in = !carbon_ff && !hydro_ff && !main_ff && res_hit;
         MODE_NOCH_RES:   is_match_in = !carbon_ff && !hydro_ff && res_hit;
         MODE_TYPE_RES:   is_match_in = type_hit && !hydro_ff && res_hit;
         MODE_NOC_MC_RES: is_match_in = !carbon_ff && !hydro_ff && main_ff && res_hit;
         MODE_MC_RES:     is_match_in = main_ff && !hydro_ff && res_hit;
         MODE_NOMC_RES:   is_match_in = !main_ff && !hydro_ff && res_hit;
         MODE_NOH_RES:    is_match_in = !hydro_ff && res_hit;
         MODE_POS_RES:    is_match_in = !hydro_ff && pos_hit && res_hit;
         MODE_NAME:       is_match_in = name_hit;
         MODE_SIDE:       is_match_in = !carbon_ff && !main_ff;
         MODE_NOC:        is_match_in = !carbon_ff;
         MODE_TYPE:       is_match_in = type_hit;
         MODE_NOC_MC:     is_match_in = !carbon_ff && main_ff;
         MODE_MC:         is_match_in = main_ff;
         MODE_NOMC:       is_match_in = !main_ff;
         MODE_ANY:        is_match_in = 1'b1;
         default: begin
            is_match_in = 1'b0;
            bad_mode_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         name_vec_ff <= name_vec_in;
         type_vec_ff <= type_vec_in;
         pos_vec_ff  <= pos_vec_in;
         res_vec_ff  <= res_vec_in;
         carbon_ff   <= carbon_in;
         hydro_ff    <= hydro_in;
         main_ff     <= main_in;
      end
      if (s1_adv) begin
         is_match_ff <= is_match_in;
         bad_mode_ff <= bad_mode_in;
      end
   end

   // table writes land when the load leaves the queue, keeping request order
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_ATOM_NAMES; k++) begin
         if (pop && head.item.kind == KIND_LOAD_ATM && 32'(head.item.entry_index) == k) begin
            atm_tab_ff[k] <= nm;
         end
      end
      for (int k = 0; k < MAX_RESIDUE_NAMES; k++) begin
         if (pop && head.item.kind == KIND_LOAD_RES && 32'(head.item.entry_index) == k) begin
            res_tab_ff[k] <= rn;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, bad_mode_ff, is_match_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/template_atom_matcher_core.sv =====
// ----------------------------------------------------------------------------
// template_atom_matcher_core
// matches protein atoms against a loaded structural template atom
// ----------------------------------------------------------------------------
// Takes one request per clock unless the response stalls. Requests are
// classified on entry; kept ones enter a two-entry queue; the back end pops
// one request per cycle unless stalled, writes the template tables for loads
// and compares a match request against every table entry in parallel, then
// decodes the match mode into a response register, which answers each match
// request; load requests and op code 3 give none. Loads take effect in request
// order. Configuration writes are applied at once and must be made while idle.
`default_nettype none

module template_atom_matcher_core import tam_pkg::*; #(
   parameter int MAX_ATOM_NAMES    = DEF_MAX_ATOM_NAMES,
   parameter int MAX_RESIDUE_NAMES = DEF_MAX_RESIDUE_NAMES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // entry_index, atom_name, residue_name
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // is_match, bad_mode
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0] mode_ff;
   logic [3:0] atom_cnt_ff;
   logic [5:0] res_cnt_ff;
   cfg_type    cfg;
   q_head_type head;
   logic       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 8'd0;
         atom_cnt_ff <= 4'd1;
         res_cnt_ff  <= 6'd1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MATCH_MODE: mode_ff     <= csr_wdata;
            CSR_ATOM_CNT:   atom_cnt_ff <= csr_wdata[3:0];
            CSR_RES_CNT:    res_cnt_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign cfg.match_mode         = mode_ff;
   assign cfg.atom_name_count    = atom_cnt_ff;
   assign cfg.residue_name_count = res_cnt_ff;

   tam_front #(
      .MAX_ATOM_NAMES   (MAX_ATOM_NAMES),
      .MAX_RESIDUE_NAMES(MAX_RESIDUE_NAMES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .head      (head),
      .pop       (pop)
   );

   tam_back #(
      .MAX_ATOM_NAMES   (MAX_ATOM_NAMES),
      .MAX_RESIDUE_NAMES(MAX_RESIDUE_NAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/tam_checker.sv =====
// ----------------------------------------------------------------------------
// tam_checker
// port-level checks of the template atom matcher
// ----------------------------------------------------------------------------
`default_nettype none
`include "template_atom_matcher_core_defines.svh"

module tam_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // a stalled response keeps its payload
   `TAM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // an unknown mode never reports a match
   `TAM_ASSERT(a_bad_no_match, clock, reset, rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0], "match flagged with bad mode")

   // padding bits stay zero
   `TAM_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[7:2] == 6'b0, "response padding not zero")

   // reset empties the pipeline and the queue
   `TAM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "response pending after reset")

endmodule

bind template_atom_matcher_core tam_checker u_tam_checker (.*);

`default_nettype wire
